/* rtl/aurr_pkg.sv */
// ----------------------------------------------------------------------------
// aurr_pkg
// Shared types and constants for the ARGB unpremultiply rectangle read block.
// ----------------------------------------------------------------------------
package aurr_pkg;

  // largest canvas dimension honored, larger register values are clamped
  localparam int unsigned MaxDim = 8192;

  // signed width for clip arithmetic: rect edge plus rect size, with margin
  localparam int unsigned CalcW = 17;

  // coordinate and channel widths
  localparam int unsigned CoordW = 13;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumLanes = 3;

  // divider layout: quotient bits, produced a few per stage
  localparam int unsigned DivBits      = ChanW;
  localparam int unsigned BitsPerStage = 2;
  localparam int unsigned NumDivStages = DivBits / BitsPerStage;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  localparam logic [CfgIdxW-1:0] CfgRectX    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRectY    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRectW    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRectH    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCanvasW  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCanvasH  = 3'd5;

  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  typedef struct packed {
    logic signed [13:0] rect_x;
    logic signed [13:0] rect_y;
    logic signed [14:0] rect_width;
    logic signed [14:0] rect_height;
    logic        [13:0] canvas_width;
    logic        [13:0] canvas_height;
  } aurr_cfg_t;

  typedef struct packed {
    logic [31:0]       pixel_word;
    logic [CoordW-1:0] src_col;
    logic [CoordW-1:0] src_row;
  } aurr_req_t;

  typedef struct packed {
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
    logic [ChanW-1:0]  alpha;
    logic [CoordW-1:0] out_col;
    logic [CoordW-1:0] out_row;
    logic              last;
  } aurr_result_t;

  // one color channel in flight through the divider
  typedef struct packed {
    logic             fix;  // quo already final (pass through or saturated)
    logic [ChanW-1:0] rem;  // partial remainder, below alpha while fix is clear
    logic [ChanW-1:0] num;  // dividend bits not yet consumed
    logic [ChanW-1:0] quo;  // quotient bits so far
  } aurr_lane_t;

  typedef struct packed {
    logic                              valid;
    logic                              last;
    logic [CoordW-1:0]                 out_col;
    logic [CoordW-1:0]                 out_row;
    logic [ChanW-1:0]                  alpha;
    aurr_lane_t [NumLanes-1:0]         lane;
  } aurr_stage_t;

endpackage

/* rtl/aurr_front.sv */
// ----------------------------------------------------------------------------
// aurr_front
// Clips the rectangle, tests the pixel and sets up the per-channel division.
// ----------------------------------------------------------------------------
module aurr_front import aurr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  aurr_cfg_t   cfg_i,
  input  logic        req_valid_i,
  input  aurr_req_t   req_i,
  output aurr_stage_t stage_o
);

  logic signed [CalcW-1:0] cw, ch;
  logic signed [CalcW-1:0] x_beg, y_beg, x_req_end, y_req_end, x_end, y_end;
  logic signed [CalcW-1:0] col_s, row_s;
  logic                    keep;
  logic [ChanW-1:0]        a;
  logic [2*ChanW-1:0]      prod;
  logic [ChanW-1:0]        c;
  aurr_stage_t             stage_d, stage_q;
  logic                    valid_q;

  always_comb begin
    cw = (CalcW'(cfg_i.canvas_width) > CalcW'(MaxDim)) ? CalcW'(MaxDim)
                                                       : CalcW'(cfg_i.canvas_width);
    ch = (CalcW'(cfg_i.canvas_height) > CalcW'(MaxDim)) ? CalcW'(MaxDim)
                                                        : CalcW'(cfg_i.canvas_height);

    // negative edge moves to zero, the far edge stays where it was
    x_beg = cfg_i.rect_x[13] ? '0 : CalcW'(cfg_i.rect_x);
    y_beg = cfg_i.rect_y[13] ? '0 : CalcW'(cfg_i.rect_y);
    x_req_end = CalcW'(cfg_i.rect_x) + CalcW'(cfg_i.rect_width);
    y_req_end = CalcW'(cfg_i.rect_y) + CalcW'(cfg_i.rect_height);
    x_end = (x_req_end > cw) ? cw : x_req_end;
    y_end = (y_req_end > ch) ? ch : y_req_end;

    col_s = CalcW'(req_i.src_col);
    row_s = CalcW'(req_i.src_row);

    // an empty area fails these tests by itself
    keep = (col_s >= x_beg) && (col_s < x_end) && (row_s >= y_beg) && (row_s < y_end);

    a = req_i.pixel_word[31:24];

    stage_d.valid   = req_valid_i && keep;
    stage_d.last    = (col_s == x_end - CalcW'(1)) && (row_s == y_end - CalcW'(1));
    stage_d.out_col = req_i.src_col - x_beg[CoordW-1:0];
    stage_d.out_row = req_i.src_row - y_beg[CoordW-1:0];
    stage_d.alpha   = a;

    for (int i = 0; i < NumLanes; i++) begin
      c    = req_i.pixel_word[23-8*i -: 8];
      // c*255 as a shift and subtract
      prod = {c, 8'd0} - {8'd0, c};
      stage_d.lane[i].rem = prod[2*ChanW-1:ChanW];
      stage_d.lane[i].num = prod[ChanW-1:0];
      if (a == '0 || a == ChanMax) begin
        stage_d.lane[i].fix = 1'b1;
        stage_d.lane[i].quo = c;
      end else if (c >= a) begin
        stage_d.lane[i].fix = 1'b1;
        stage_d.lane[i].quo = ChanMax;
      end else begin
        stage_d.lane[i].fix = 1'b0;
        stage_d.lane[i].quo = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

/* rtl/aurr_div_stage.sv */
// ----------------------------------------------------------------------------
// aurr_div_stage
// One pipeline stage of the restoring divider, a few quotient bits per lane.
// ----------------------------------------------------------------------------
module aurr_div_stage import aurr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  aurr_stage_t stage_i,
  output aurr_stage_t stage_o
);

  aurr_stage_t      stage_d, stage_q;
  logic             valid_q;
  logic [ChanW:0]   trial;
  logic             qbit;

  always_comb begin
    stage_d = stage_i;
    for (int i = 0; i < NumLanes; i++) begin
      for (int s = 0; s < BitsPerStage; s++) begin
        trial = {stage_d.lane[i].rem, stage_d.lane[i].num[ChanW-1]};
        qbit  = (trial >= {1'b0, stage_i.alpha});
        if (!stage_d.lane[i].fix) begin
          stage_d.lane[i].rem = qbit ? ChanW'(trial - {1'b0, stage_i.alpha})
                                     : trial[ChanW-1:0];
          stage_d.lane[i].num = {stage_d.lane[i].num[ChanW-2:0], 1'b0};
          stage_d.lane[i].quo = {stage_d.lane[i].quo[ChanW-2:0], qbit};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

/* rtl/argb_unpremultiply_rect_read.sv */
// ----------------------------------------------------------------------------
// argb_unpremultiply_rect_read
// Clipped rectangle read of premultiplied ARGB pixels, converted to straight
// RGBA with exact per-channel division.
// ----------------------------------------------------------------------------
// path: a taken request passes the front register, then the divider registers in order
// throughput: one request per clock, busy never rises; the pipeline is the
//   clip front stage plus four divider stages of two quotient bits each
// dropped pixels simply leave no result strobe
// reset clears the configuration registers and all stage valid bits
// the receiver takes every result in its one strobe cycle
module argb_unpremultiply_rect_read import aurr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // pixel requests
  input  logic                start,
  output logic                busy,
  input  aurr_req_t           req_i,
  // results
  output logic                result_valid_o,
  output aurr_result_t        result_o,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  aurr_cfg_t   cfg_q;
  aurr_stage_t stage [NumDivStages+1];
  logic        req_take;

  // never stalls, so every request is taken
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign req_take    = start && !busy;

  // configuration registers, unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgRectX:   cfg_q.rect_x        <= cfg_data_i[13:0];
        CfgRectY:   cfg_q.rect_y        <= cfg_data_i[13:0];
        CfgRectW:   cfg_q.rect_width    <= cfg_data_i[14:0];
        CfgRectH:   cfg_q.rect_height   <= cfg_data_i[14:0];
        CfgCanvasW: cfg_q.canvas_width  <= cfg_data_i[13:0];
        CfgCanvasH: cfg_q.canvas_height <= cfg_data_i[13:0];
        default: begin
        end
      endcase
    end
  end

  // front: clip test, channel split, dividend setup
  aurr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (req_take),
    .req_i       (req_i),
    .stage_o     (stage[0])
  );

  // divider chain, each stage adds two quotient bits to every channel
  for (genvar k = 0; k < NumDivStages; k++) begin : g_div
    aurr_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (stage[k]),
      .stage_o (stage[k+1])
    );
  end

  // the last divider register drives the result port directly
  assign result_valid_o   = stage[NumDivStages].valid;
  assign result_o.red     = stage[NumDivStages].lane[0].quo;
  assign result_o.green   = stage[NumDivStages].lane[1].quo;
  assign result_o.blue    = stage[NumDivStages].lane[2].quo;
  assign result_o.alpha   = stage[NumDivStages].alpha;
  assign result_o.out_col = stage[NumDivStages].out_col;
  assign result_o.out_row = stage[NumDivStages].out_row;
  assign result_o.last    = stage[NumDivStages].last;

endmodule
